/* hdl/bts_pkg.sv */
package bts_pkg;

  localparam int STORE_BYTES   = 65536;
  localparam int STORE_AW      = $clog2(STORE_BYTES);
  localparam int FRAC_BITS_DEF = 8;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

  localparam int CFG_DATA_W = 9;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] store_address;
    logic [7:0]  store_byte;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [1:0]  channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sample_value;
    logic       channel_invalid;
  } out_item_t;

endpackage

/* hdl/bilinear_texel_sampler_unit.sv */
// Bilinear texel sampler with clamp-to-edge addressing over an interleaved
// 8-bit image held in a 64 KiB byte store. A write item (mode 0) stores one
// byte and gives no result; a sample item (mode 1) gives one result from the
// sum stage. One item is accepted every cycle while the result side
// keeps up: the six register stages (clamp, row multiply, address and weight
// multiply, store read, texel multiply, sum) each hold one item, and the four
// texel reads per sample come from two copies of the store, each read at two
// addresses per cycle, both updated by every write item. The store is not
// cleared by reset; sample only texels that were written. Write the image
// size and channel count registers only while no item is in flight.
module bilinear_texel_sampler_unit #(
  parameter int FRAC_BITS = bts_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bts_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bts_pkg::out_item_t             out_item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bts_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bts_pkg::*;

  localparam int XW   = 17 - FRAC_BITS;
  localparam int CMPW = (XW > 9) ? XW : 9;
  localparam int WW   = FRAC_BITS + 1;
  localparam int PW   = 2 * WW;
  localparam int TW   = PW + 8;
  localparam int SW   = TW + 2;
  localparam logic [WW-1:0] SCALE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [8:0] width_r;
  logic [8:0] height_r;
  logic [2:0] ccount_r;

  logic en1, en2, en3, en4, en5, en6;

  logic                 s1_v_r, s1_mode_r, s1_inv_r;
  logic [STORE_AW-1:0]  s1_waddr_r;
  logic [7:0]           s1_wbyte_r;
  logic [8:0]           s1_x0_r, s1_x1_r, s1_y0_r, s1_y1_r;
  logic [FRAC_BITS-1:0] s1_fx_r, s1_fy_r;
  logic [1:0]           s1_ch_r;

  logic                 s2_v_r, s2_mode_r, s2_inv_r;
  logic [STORE_AW-1:0]  s2_waddr_r;
  logic [7:0]           s2_wbyte_r;
  logic [8:0]           s2_x0_r, s2_x1_r;
  logic [STORE_AW-1:0]  s2_yw0_r, s2_yw1_r;
  logic [WW-1:0]        s2_wx0_r, s2_wx1_r, s2_wy0_r, s2_wy1_r;
  logic [1:0]           s2_ch_r;

  logic                 s3_v_r, s3_mode_r, s3_inv_r;
  logic [STORE_AW-1:0]  s3_waddr_r;
  logic [7:0]           s3_wbyte_r;
  logic [STORE_AW-1:0]  s3_a00_r, s3_a10_r, s3_a01_r, s3_a11_r;
  logic [PW-1:0]        s3_w00_r, s3_w10_r, s3_w01_r, s3_w11_r;

  logic                 s4_v_r, s4_inv_r;
  logic [7:0]           s4_t00_r, s4_t10_r, s4_t01_r, s4_t11_r;
  logic [PW-1:0]        s4_w00_r, s4_w10_r, s4_w01_r, s4_w11_r;

  logic                 s5_v_r, s5_inv_r;
  logic [TW-1:0]        s5_p00_r, s5_p10_r, s5_p01_r, s5_p11_r;

  logic                 out_valid_r;
  out_item_t            out_item_r;

  logic [7:0] store_a_mem [STORE_BYTES];
  logic [7:0] store_b_mem [STORE_BYTES];

  logic [XW-1:0]        xi_nxt, yi_nxt;
  logic [8:0]           x0_nxt, x1_nxt, y0_nxt, y1_nxt;
  logic                 inv_nxt;
  logic [17:0]          yw0_full, yw1_full;
  logic [SW-1:0]        sum_nxt;
  out_item_t            out_item_nxt;

  function automatic logic [8:0] clamp_edge(input logic [CMPW-1:0] v,
                                            input logic [8:0] size);
    logic [8:0] last;
    last = (size == 9'd0) ? 9'd0 : size - 9'd1;
    return (v > CMPW'(last)) ? last : v[8:0];
  endfunction

  function automatic logic [STORE_AW-1:0] texel_addr(input logic [STORE_AW-1:0] yw,
                                                     input logic [8:0] x,
                                                     input logic [2:0] cc,
                                                     input logic [1:0] ch);
    logic [STORE_AW-1:0] row;
    logic [STORE_AW-1:0] scaled;
    row    = yw + STORE_AW'(x);
    scaled = row * STORE_AW'(cc);
    return scaled + STORE_AW'(ch);
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd1;
      height_r <= 9'd1;
      ccount_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:   width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:  height_r <= cfg_data;
        CFG_CHANNEL_COUNT: ccount_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign en6 = !out_valid_r || out_ready;
  assign en5 = !s5_v_r || en6;
  assign en4 = !s4_v_r || en5;
  assign en3 = !s3_v_r || en4;
  assign en2 = !s2_v_r || en3;
  assign en1 = !s1_v_r || en2;
  assign in_ready = en1;

  always_comb begin
    xi_nxt  = XW'({1'b0, in_item.x_coord} >> FRAC_BITS);
    yi_nxt  = XW'({1'b0, in_item.y_coord} >> FRAC_BITS);
    x0_nxt  = clamp_edge(CMPW'(xi_nxt), width_r);
    x1_nxt  = clamp_edge(CMPW'(xi_nxt + XW'(1)), width_r);
    y0_nxt  = clamp_edge(CMPW'(yi_nxt), height_r);
    y1_nxt  = clamp_edge(CMPW'(yi_nxt + XW'(1)), height_r);
    inv_nxt = {1'b0, in_item.channel} >= ccount_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_mode_r  <= in_item.mode;
      s1_inv_r   <= inv_nxt;
      s1_waddr_r <= STORE_AW'(in_item.store_address);
      s1_wbyte_r <= in_item.store_byte;
      s1_x0_r    <= x0_nxt;
      s1_x1_r    <= x1_nxt;
      s1_y0_r    <= y0_nxt;
      s1_y1_r    <= y1_nxt;
      s1_fx_r    <= in_item.x_coord[FRAC_BITS-1:0];
      s1_fy_r    <= in_item.y_coord[FRAC_BITS-1:0];
      s1_ch_r    <= in_item.channel;
    end
  end

  assign yw0_full = s1_y0_r * width_r;
  assign yw1_full = s1_y1_r * width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_mode_r  <= s1_mode_r;
      s2_inv_r   <= s1_inv_r;
      s2_waddr_r <= s1_waddr_r;
      s2_wbyte_r <= s1_wbyte_r;
      s2_x0_r    <= s1_x0_r;
      s2_x1_r    <= s1_x1_r;
      s2_yw0_r   <= STORE_AW'(yw0_full);
      s2_yw1_r   <= STORE_AW'(yw1_full);
      s2_wx0_r   <= SCALE - {1'b0, s1_fx_r};
      s2_wx1_r   <= {1'b0, s1_fx_r};
      s2_wy0_r   <= SCALE - {1'b0, s1_fy_r};
      s2_wy1_r   <= {1'b0, s1_fy_r};
      s2_ch_r    <= s1_ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_mode_r  <= s2_mode_r;
      s3_inv_r   <= s2_inv_r;
      s3_waddr_r <= s2_waddr_r;
      s3_wbyte_r <= s2_wbyte_r;
      s3_a00_r   <= texel_addr(s2_yw0_r, s2_x0_r, ccount_r, s2_ch_r);
      s3_a10_r   <= texel_addr(s2_yw0_r, s2_x1_r, ccount_r, s2_ch_r);
      s3_a01_r   <= texel_addr(s2_yw1_r, s2_x0_r, ccount_r, s2_ch_r);
      s3_a11_r   <= texel_addr(s2_yw1_r, s2_x1_r, ccount_r, s2_ch_r);
      s3_w00_r   <= PW'(s2_wx0_r) * PW'(s2_wy0_r);
      s3_w10_r   <= PW'(s2_wx1_r) * PW'(s2_wy0_r);
      s3_w01_r   <= PW'(s2_wx0_r) * PW'(s2_wy1_r);
      s3_w11_r   <= PW'(s2_wx1_r) * PW'(s2_wy1_r);
    end
  end

  // drop write items here: they end at the store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en4) begin
      s4_v_r <= s3_v_r && (s3_mode_r == MODE_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      if (s3_v_r && (s3_mode_r == MODE_WRITE)) begin
        store_a_mem[s3_waddr_r] <= s3_wbyte_r;
        store_b_mem[s3_waddr_r] <= s3_wbyte_r;
      end
      s4_t00_r <= store_a_mem[s3_a00_r];
      s4_t10_r <= store_a_mem[s3_a10_r];
      s4_t01_r <= store_b_mem[s3_a01_r];
      s4_t11_r <= store_b_mem[s3_a11_r];
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_inv_r <= s3_inv_r;
      s4_w00_r <= s3_w00_r;
      s4_w10_r <= s3_w10_r;
      s4_w01_r <= s3_w01_r;
      s4_w11_r <= s3_w11_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en5) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_inv_r <= s4_inv_r;
      s5_p00_r <= TW'(s4_w00_r) * TW'(s4_t00_r);
      s5_p10_r <= TW'(s4_w10_r) * TW'(s4_t10_r);
      s5_p01_r <= TW'(s4_w01_r) * TW'(s4_t01_r);
      s5_p11_r <= TW'(s4_w11_r) * TW'(s4_t11_r);
    end
  end

  always_comb begin
    sum_nxt = SW'(s5_p00_r) + SW'(s5_p10_r) + SW'(s5_p01_r) + SW'(s5_p11_r);
    out_item_nxt.sample_value    = s5_inv_r ? 8'd0 : 8'(sum_nxt >> (2 * FRAC_BITS));
    out_item_nxt.channel_invalid = s5_inv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en6) begin
      out_valid_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
